// ===== hw/rtl/tpc_pkg.sv =====
// Shared widths, types and constants of the triangle plane clipper.
`default_nettype none

package tpc_pkg;

   // Coordinate width of every vertex field and plane register (Q16.16 at 32).
   localparam int COORD_BITS = 32;

   // Arithmetic widths that follow from the coordinate width.
   localparam int DIF_W  = COORD_BITS + 1;       // P - plane, Q - P
   localparam int PROD_W = DIF_W + COORD_BITS;   // one term of the dot product
   localparam int DIST_W = PROD_W + 2;           // sum of three terms
   localparam int DEN_W  = DIST_W + 1;           // d(Q) - d(P)
   localparam int NUM_W  = DIST_W + 16;          // |d(P)| << 16
   localparam int QW     = 33;                   // quotient bits kept by the divider
   localparam int RW     = DEN_W + QW;           // divider remainder width
   localparam int FW     = 32;                   // saturated crossing fraction
   localparam int MUL_W  = DIF_W + FW;           // (Q - P) * f
   localparam int RES_W  = MUL_W - 15;           // P - ((Q - P) * f >>> 16)

   // Register stages of one edge-crossing lane, from operand select to result.
   localparam int LANE_LAT = QW + 6;

   // Configuration port geometry.
   localparam int CSR_DW   = (COORD_BITS > 32) ? 64 : 32;
   localparam int CSR_AS   = (COORD_BITS > 32) ? 3 : 2;
   localparam int CSR_AW   = CSR_AS + 3;
   localparam int IDX_W    = CSR_AW - CSR_AS;
   localparam int NUM_REGS = 6;

   // Register indexes.
   localparam logic [IDX_W-1:0] REG_PLANE_X  = 3'd0;
   localparam logic [IDX_W-1:0] REG_PLANE_Y  = 3'd1;
   localparam logic [IDX_W-1:0] REG_PLANE_Z  = 3'd2;
   localparam logic [IDX_W-1:0] REG_NORMAL_X = 3'd3;
   localparam logic [IDX_W-1:0] REG_NORMAL_Y = 3'd4;
   localparam logic [IDX_W-1:0] REG_NORMAL_Z = 3'd5;

   localparam logic [COORD_BITS-1:0] NORMAL_Z_RESET = COORD_BITS'(65536);

   // Saturation limits.
   localparam logic signed [FW-1:0] Q_MAX = {1'b0, {(FW-1){1'b1}}};
   localparam logic signed [FW-1:0] Q_MIN = {1'b1, {(FW-1){1'b0}}};
   localparam logic [QW-1:0] Q_POS_LIM = QW'({1'b0, {(FW-1){1'b1}}});
   localparam logic [QW-1:0] Q_NEG_LIM = QW'({1'b1, {(FW-1){1'b0}}});
   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   // Vertex: index 0 is x, 1 is y, 2 is z.
   typedef logic [2:0][COORD_BITS-1:0] vtx_type;
   // Triangle: index 0 is A, 1 is B, 2 is C.
   typedef vtx_type [2:0] tri_type;
   typedef logic [2:0][DIF_W-1:0] dif3_type;

   // How a triangle relates to the plane.
   typedef enum logic [2:0] {
      CLS_ALLPOS,
      CLS_ALLNEG,
      CLS_TWO_A,
      CLS_TWO_B,
      CLS_TWO_C,
      CLS_ONE_A,
      CLS_ONE_B,
      CLS_ONE_C
   } cls_type;

   // Operands of one edge crossing X(P, Q).
   typedef struct packed {
      vtx_type           p;
      vtx_type           q;
      logic [DIST_W-1:0] dp;
      logic [DIST_W-1:0] dq;
   } lane_in_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tpc_if.sv =====
// Request and response channel interfaces of the triangle plane clipper.
`default_nettype none

interface tpc_req_if import tpc_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_x;
   logic signed [COORD_BITS-1:0] a_y;
   logic signed [COORD_BITS-1:0] a_z;
   logic signed [COORD_BITS-1:0] b_x;
   logic signed [COORD_BITS-1:0] b_y;
   logic signed [COORD_BITS-1:0] b_z;
   logic signed [COORD_BITS-1:0] c_x;
   logic signed [COORD_BITS-1:0] c_y;
   logic signed [COORD_BITS-1:0] c_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                 output ready);
endinterface

interface tpc_rsp_if import tpc_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_a_x;
   logic signed [COORD_BITS-1:0] out_a_y;
   logic signed [COORD_BITS-1:0] out_a_z;
   logic signed [COORD_BITS-1:0] out_b_x;
   logic signed [COORD_BITS-1:0] out_b_y;
   logic signed [COORD_BITS-1:0] out_b_z;
   logic signed [COORD_BITS-1:0] out_c_x;
   logic signed [COORD_BITS-1:0] out_c_y;
   logic signed [COORD_BITS-1:0] out_c_z;
   logic                         last;

   modport source (output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y,
                   out_b_z, out_c_x, out_c_y, out_c_z, last, input ready);
   modport sink (input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y,
                 out_b_z, out_c_x, out_c_y, out_c_z, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tpc_lane.sv =====
// One edge-crossing lane: pipelined divider, fraction saturation and interpolation.
`default_nettype none

module tpc_lane import tpc_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  lane_in_type lane_in,
   output vtx_type     cross_out
);

   // Data that rides alongside the divider.
   typedef struct packed {
      vtx_type  p;
      dif3_type qmp;
      logic     num_neg;
      logic     num_zero;
      logic     den_neg;
      logic     den_zero;
      logic     ovf;
   } side_type;

   // Stage L0: edge vector and denominator.
   vtx_type                  l0_p_ff;
   dif3_type                 l0_qmp_ff, l0_qmp_in;
   logic signed [DIST_W-1:0] l0_dp_ff;
   logic signed [DEN_W-1:0]  l0_den_ff, l0_den_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         l0_qmp_in[i] = DIF_W'($signed(lane_in.q[i])) - DIF_W'($signed(lane_in.p[i]));
      end
      l0_den_in = DEN_W'($signed(lane_in.dq)) - DEN_W'($signed(lane_in.dp));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l0_p_ff   <= lane_in.p;
         l0_qmp_ff <= l0_qmp_in;
         l0_dp_ff  <= $signed(lane_in.dp);
         l0_den_ff <= l0_den_in;
      end
   end

   // Stage L1: signs and magnitudes.
   side_type            l1_side_ff, l1_side_in;
   logic [DIST_W-1:0]   l1_nabs_ff, l1_nabs_in;
   logic [DEN_W-1:0]    l1_dabs_ff, l1_dabs_in;

   always_comb begin
      l1_side_in          = '0;
      l1_side_in.p        = l0_p_ff;
      l1_side_in.qmp      = l0_qmp_ff;
      l1_side_in.num_neg  = l0_dp_ff[DIST_W-1];
      l1_side_in.num_zero = (l0_dp_ff == '0);
      l1_side_in.den_neg  = l0_den_ff[DEN_W-1];
      l1_side_in.den_zero = (l0_den_ff == '0);
      l1_nabs_in = l0_dp_ff[DIST_W-1] ? (~l0_dp_ff + 1'b1) : l0_dp_ff;
      l1_dabs_in = l0_den_ff[DEN_W-1] ? (~l0_den_ff + 1'b1) : l0_den_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l1_side_ff <= l1_side_in;
         l1_nabs_ff <= l1_nabs_in;
         l1_dabs_ff <= l1_dabs_in;
      end
   end

   // Stage L2 (divider entry) and one restoring step per stage after it.
   // A quotient of 2^33 or more is flagged at entry, so the steps only
   // need to produce the lower 33 quotient bits.
   logic [RW-1:0]    r_ff [0:QW-1];
   logic [DEN_W-1:0] d_ff [0:QW-1];
   logic [QW-1:0]    q_ff [0:QW];
   side_type         s_ff [0:QW];
   logic [RW-1:0]    num_ext;
   logic [RW-1:0]    den_top;
   side_type         s_entry;

   always_comb begin
      num_ext     = RW'({l1_nabs_ff, 16'b0});
      den_top     = RW'(l1_dabs_ff) << QW;
      s_entry     = l1_side_ff;
      s_entry.ovf = (num_ext >= den_top);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0]     <= num_ext;
         d_ff[0]     <= l1_dabs_ff;
         q_ff[0]     <= '0;
         s_ff[0]     <= s_entry;
         for (int k = 0; k < QW; k++) begin
            if (r_ff[k] >= (RW'(d_ff[k]) << (QW - 1 - k))) begin
               q_ff[k+1] <= q_ff[k] | (QW'(1) << (QW - 1 - k));
               if (k < QW - 1) begin
                  r_ff[k+1] <= r_ff[k] - (RW'(d_ff[k]) << (QW - 1 - k));
               end
            end else begin
               q_ff[k+1] <= q_ff[k];
               if (k < QW - 1) begin
                  r_ff[k+1] <= r_ff[k];
               end
            end
            if (k < QW - 1) begin
               d_ff[k+1] <= d_ff[k];
            end
            s_ff[k+1] <= s_ff[k];
         end
      end
   end

   // Stage F: signed, saturated fraction.
   logic signed [FW-1:0] f_ff, f_in;
   vtx_type              f_p_ff;
   dif3_type             f_qmp_ff;
   logic                 quo_neg;
   logic                 quo_sat;

   always_comb begin
      quo_neg = s_ff[QW].num_neg ^ s_ff[QW].den_neg;
      quo_sat = s_ff[QW].ovf ||
                (quo_neg ? (q_ff[QW] > Q_NEG_LIM) : (q_ff[QW] > Q_POS_LIM));
      if (s_ff[QW].den_zero) begin
         if (s_ff[QW].num_zero) begin
            f_in = '0;
         end else begin
            f_in = s_ff[QW].num_neg ? Q_MIN : Q_MAX;
         end
      end else if (quo_sat) begin
         f_in = quo_neg ? Q_MIN : Q_MAX;
      end else if (quo_neg) begin
         f_in = $signed(FW'(QW'(0) - q_ff[QW]));
      end else begin
         f_in = $signed(FW'(q_ff[QW]));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff     <= f_in;
         f_p_ff   <= s_ff[QW].p;
         f_qmp_ff <= s_ff[QW].qmp;
      end
   end

   // Stage M: scale the edge vector by the fraction.
   logic signed [MUL_W-1:0] m_prod_ff [0:2];
   logic signed [MUL_W-1:0] m_prod_in [0:2];
   vtx_type                 m_p_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_prod_in[i] = $signed(f_qmp_ff[i]) * f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            m_prod_ff[i] <= m_prod_in[i];
         end
         m_p_ff <= f_p_ff;
      end
   end

   // Stage O: subtract the floored offset and clamp to the coordinate range.
   vtx_type                  o_ff, o_in;
   logic signed [RES_W-1:0]  o_res [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         o_res[i] = RES_W'($signed(m_p_ff[i])) -
                    RES_W'($signed(m_prod_ff[i][MUL_W-1:16]));
         if (o_res[i] > RES_W'(C_MAX)) begin
            o_in[i] = C_MAX;
         end else if (o_res[i] < RES_W'(C_MIN)) begin
            o_in[i] = C_MIN;
         end else begin
            o_in[i] = o_res[i][COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_ff <= o_in;
      end
   end

   assign cross_out = o_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_plane_clipper.sv =====
// Top level of the triangle plane clipper: distances, classification, lanes, output.
//
// The block accepts one triangle request in every cycle unless the response register
// is held, and returns zero, one or two clipped triangles per request, in order, with
// last set on the final one. A request that yields two triangles holds the response
// register until its second triangle is taken, so sustained throughput is one request
// per cycle for single results when each response is taken at once. Stages T1, T2 and
// T3 form the signed plane distances; each edge-crossing lane runs through L0, L1, then
// the restoring divider, which resolves one quotient bit per stage for 33 bits, then F,
// M and O, and the response register follows them.
// A stalled response stalls the whole pipeline; nothing is lost or repeated.
// Plane registers sit at byte addresses 0, 4, 8 (point) and 12, 16, 20
// (normal) and should be written only while the block is empty.
`default_nettype none

module triangle_plane_clipper import tpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tpc_req_if.sink           req_chan,
   tpc_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // Configuration registers.
   logic [COORD_BITS-1:0] cfg_ff [0:NUM_REGS-1];
   logic [IDX_W-1:0]      csr_idx;

   assign csr_idx    = csr_paddr[CSR_AW-1:CSR_AS];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= (i == int'(REG_NORMAL_Z)) ? NORMAL_Z_RESET : '0;
         end
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_idx < IDX_W'(NUM_REGS))) begin
         cfg_ff[csr_idx] <= csr_pwdata[COORD_BITS-1:0];
      end
   end

   always_comb begin
      if (csr_idx < IDX_W'(NUM_REGS)) begin
         csr_prdata = CSR_DW'(cfg_ff[csr_idx]);
      end else begin
         csr_prdata = '0;
      end
   end

   // Global advance: the pipeline moves unless the response register is held.
   logic ob_valid_ff, ob_two_ff, ob_phase_ff;
   logic hold;
   logic adv;

   assign hold = ob_valid_ff && !(rsp_chan.ready && (!ob_two_ff || ob_phase_ff));
   assign adv  = !hold;
   assign req_chan.ready = adv;

   // Stage T1: vertex minus plane point.
   tri_type  req_tri;
   tri_type  t1_tri_ff;
   dif3_type t1_dif_ff [0:2];
   dif3_type t1_dif_in [0:2];
   logic     t1_valid_ff;

   assign req_tri[0] = {req_chan.a_z, req_chan.a_y, req_chan.a_x};
   assign req_tri[1] = {req_chan.b_z, req_chan.b_y, req_chan.b_x};
   assign req_tri[2] = {req_chan.c_z, req_chan.c_y, req_chan.c_x};

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int i = 0; i < 3; i++) begin
            t1_dif_in[v][i] = DIF_W'($signed(req_tri[v][i])) -
                              DIF_W'($signed(cfg_ff[REG_PLANE_X + i]));
         end
      end
   end

   // Stage T2: products with the normal.
   tri_type                 t2_tri_ff;
   logic signed [PROD_W-1:0] t2_prod_ff [0:2][0:2];
   logic                    t2_valid_ff;

   // Stage T3: signed distances.
   tri_type                  t3_tri_ff;
   logic signed [DIST_W-1:0] t3_dist_ff [0:2];
   logic                     t3_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_tri_ff <= req_tri;
         t2_tri_ff <= t1_tri_ff;
         t3_tri_ff <= t2_tri_ff;
         for (int v = 0; v < 3; v++) begin
            t1_dif_ff[v] <= t1_dif_in[v];
            for (int i = 0; i < 3; i++) begin
               t2_prod_ff[v][i] <= $signed(t1_dif_ff[v][i]) *
                                   $signed(cfg_ff[REG_NORMAL_X + i]);
            end
            t3_dist_ff[v] <= DIST_W'(t2_prod_ff[v][0]) + DIST_W'(t2_prod_ff[v][1]) +
                             DIST_W'(t2_prod_ff[v][2]);
         end
      end
   end

   // Classification and choice of the edge that each crossing lane cuts.
   logic [2:0]  d_neg, d_zero, d_pos;
   cls_type     cls;
   lane_in_type lane0_in, lane1_in;

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         d_neg[v]  = t3_dist_ff[v][DIST_W-1];
         d_zero[v] = (t3_dist_ff[v] == '0);
         d_pos[v]  = !d_neg[v] && !d_zero[v];
      end
      if (d_pos == 3'b111) begin
         cls = CLS_ALLPOS;
      end else if (d_neg == 3'b111) begin
         cls = CLS_ALLNEG;
      end else if (d_zero == 3'b000 && $onehot(d_neg)) begin
         if (d_neg[0]) begin
            cls = CLS_TWO_A;
         end else if (d_neg[1]) begin
            cls = CLS_TWO_B;
         end else begin
            cls = CLS_TWO_C;
         end
      end else if (d_pos[0]) begin
         cls = CLS_ONE_A;
      end else if (d_pos[1]) begin
         cls = CLS_ONE_B;
      end else begin
         cls = CLS_ONE_C;
      end
   end

   // Edge X(P, Q) for a lane: vertex indexes of P and Q.
   function automatic lane_in_type pick(input tri_type t,
                                        input logic [DIST_W-1:0] d0,
                                        input logic [DIST_W-1:0] d1,
                                        input logic [DIST_W-1:0] d2,
                                        input logic [1:0] pi,
                                        input logic [1:0] qi);
      lane_in_type r;
      logic [DIST_W-1:0] dv [0:2];
      dv[0] = d0;
      dv[1] = d1;
      dv[2] = d2;
      r.p  = t[pi];
      r.q  = t[qi];
      r.dp = dv[pi];
      r.dq = dv[qi];
      return r;
   endfunction

   always_comb begin
      case (cls)
         CLS_TWO_A: begin
            lane0_in = pick(t3_tri_ff, t3_dist_ff[0], t3_dist_ff[1], t3_dist_ff[2], 2'd1, 2'd0);
            lane1_in = pick(t3_tri_ff, t3_dist_ff[0], t3_dist_ff[1], t3_dist_ff[2], 2'd2, 2'd0);
         end
         CLS_TWO_B: begin
            lane0_in = pick(t3_tri_ff, t3_dist_ff[0], t3_dist_ff[1], t3_dist_ff[2], 2'd2, 2'd1);
            lane1_in = pick(t3_tri_ff, t3_dist_ff[0], t3_dist_ff[1], t3_dist_ff[2], 2'd0, 2'd1);
         end
         CLS_TWO_C: begin
            lane0_in = pick(t3_tri_ff, t3_dist_ff[0], t3_dist_ff[1], t3_dist_ff[2], 2'd0, 2'd2);
            lane1_in = pick(t3_tri_ff, t3_dist_ff[0], t3_dist_ff[1], t3_dist_ff[2], 2'd1, 2'd2);
         end
         CLS_ONE_B: begin
            lane0_in = pick(t3_tri_ff, t3_dist_ff[0], t3_dist_ff[1], t3_dist_ff[2], 2'd0, 2'd1);
            lane1_in = pick(t3_tri_ff, t3_dist_ff[0], t3_dist_ff[1], t3_dist_ff[2], 2'd1, 2'd2);
         end
         CLS_ONE_C: begin
            lane0_in = pick(t3_tri_ff, t3_dist_ff[0], t3_dist_ff[1], t3_dist_ff[2], 2'd1, 2'd2);
            lane1_in = pick(t3_tri_ff, t3_dist_ff[0], t3_dist_ff[1], t3_dist_ff[2], 2'd0, 2'd2);
         end
         default: begin
            lane0_in = pick(t3_tri_ff, t3_dist_ff[0], t3_dist_ff[1], t3_dist_ff[2], 2'd0, 2'd1);
            lane1_in = pick(t3_tri_ff, t3_dist_ff[0], t3_dist_ff[1], t3_dist_ff[2], 2'd0, 2'd2);
         end
      endcase
   end

   // The two crossing lanes.
   vtx_type p1, p2;

   tpc_lane u_lane0 (
      .clock     (clock),
      .adv       (adv),
      .lane_in   (lane0_in),
      .cross_out (p1)
   );

   tpc_lane u_lane1 (
      .clock     (clock),
      .adv       (adv),
      .lane_in   (lane1_in),
      .cross_out (p2)
   );

   // Context line that stays aligned with the lanes.
   logic    ctx_valid_ff [0:LANE_LAT-1];
   cls_type ctx_cls_ff   [0:LANE_LAT-1];
   tri_type ctx_tri_ff   [0:LANE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         t3_valid_ff <= 1'b0;
         for (int s = 0; s < LANE_LAT; s++) begin
            ctx_valid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         t1_valid_ff     <= req_chan.valid;
         t2_valid_ff     <= t1_valid_ff;
         t3_valid_ff     <= t2_valid_ff;
         ctx_valid_ff[0] <= t3_valid_ff;
         for (int s = 1; s < LANE_LAT; s++) begin
            ctx_valid_ff[s] <= ctx_valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx_cls_ff[0] <= cls;
         ctx_tri_ff[0] <= t3_tri_ff;
         for (int s = 1; s < LANE_LAT; s++) begin
            ctx_cls_ff[s] <= ctx_cls_ff[s-1];
            ctx_tri_ff[s] <= ctx_tri_ff[s-1];
         end
      end
   end

   // Assemble the result triangles. The patterns list vertex C first,
   // since index 2 is the left bound of the triangle type.
   tri_type end_tri;
   cls_type end_cls;
   logic    end_valid;
   tri_type tri0_in, tri1_in;
   logic    two_in;

   assign end_tri   = ctx_tri_ff[LANE_LAT-1];
   assign end_cls   = ctx_cls_ff[LANE_LAT-1];
   assign end_valid = ctx_valid_ff[LANE_LAT-1];

   always_comb begin
      tri0_in = end_tri;
      tri1_in = end_tri;
      two_in  = 1'b0;
      case (end_cls)
         CLS_TWO_A: begin
            tri0_in = '{end_tri[2], end_tri[1], p1};
            tri1_in = '{p2, end_tri[2], p1};
            two_in  = 1'b1;
         end
         CLS_TWO_B: begin
            tri0_in = '{end_tri[0], end_tri[2], p1};
            tri1_in = '{p2, end_tri[0], p1};
            two_in  = 1'b1;
         end
         CLS_TWO_C: begin
            tri0_in = '{end_tri[1], end_tri[0], p1};
            tri1_in = '{p2, end_tri[1], p1};
            two_in  = 1'b1;
         end
         CLS_ONE_A: tri0_in = '{p2, p1, end_tri[0]};
         CLS_ONE_B: tri0_in = '{p2, end_tri[1], p1};
         CLS_ONE_C: tri0_in = '{end_tri[2], p1, p2};
         default:   tri0_in = end_tri;
      endcase
   end

   // Response register; a split request shows its two triangles in turn.
   tri_type ob_tri0_ff, ob_tri1_ff;
   tri_type rsp_tri;

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_valid_ff <= 1'b0;
         ob_phase_ff <= 1'b0;
         ob_two_ff   <= 1'b0;
      end else if (adv) begin
         ob_valid_ff <= end_valid && (end_cls != CLS_ALLNEG);
         ob_phase_ff <= 1'b0;
         ob_two_ff   <= two_in;
      end else if (rsp_chan.ready) begin
         ob_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ob_tri0_ff <= tri0_in;
         ob_tri1_ff <= tri1_in;
      end
   end

   assign rsp_tri          = ob_phase_ff ? ob_tri1_ff : ob_tri0_ff;
   assign rsp_chan.valid   = ob_valid_ff;
   assign rsp_chan.last    = !ob_two_ff || ob_phase_ff;
   assign rsp_chan.out_a_x = rsp_tri[0][0];
   assign rsp_chan.out_a_y = rsp_tri[0][1];
   assign rsp_chan.out_a_z = rsp_tri[0][2];
   assign rsp_chan.out_b_x = rsp_tri[1][0];
   assign rsp_chan.out_b_y = rsp_tri[1][1];
   assign rsp_chan.out_b_z = rsp_tri[1][2];
   assign rsp_chan.out_c_x = rsp_tri[2][0];
   assign rsp_chan.out_c_y = rsp_tri[2][1];
   assign rsp_chan.out_c_z = rsp_tri[2][2];

   // The second triangle of a split request follows the first one.
   assert property (@(posedge clock) disable iff (reset)
      ob_valid_ff && ob_two_ff && !ob_phase_ff && rsp_chan.ready
      |=> ob_valid_ff && ob_phase_ff)
      else $error("second triangle of a split request was not presented");

   // A surviving request leaving the lanes lands in the response register.
   assert property (@(posedge clock) disable iff (reset)
      adv && end_valid && (end_cls != CLS_ALLNEG) |=> ob_valid_ff && !ob_phase_ff)
      else $error("result of a request was dropped at the response register");

   // The second phase exists only for a held split request.
   assert property (@(posedge clock) disable iff (reset)
      ob_phase_ff |-> ob_valid_ff && ob_two_ff)
      else $error("response phase set without a split request");

   // A stall freezes the end of the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(end_valid) && $stable(end_cls))
      else $error("pipeline moved while the response was held");

endmodule

`default_nettype wire
